### hdl/nearest_palette_color_core_defines.svh
// assertion macros shared by the nearest palette colour core
// depends on nothing; taken in by files that assert
`ifndef NEAREST_PALETTE_COLOR_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define NPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/npc_pkg.sv
// shared constants and types for the nearest palette colour core
// no dependencies
`default_nettype none

package npc_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
	localparam int CHAN_W          = 8;
	localparam int ENTRY_W         = 3 * CHAN_W;
	localparam int COLOR_W         = 8;
	localparam int DIST_W          = CHAN_W + 2;

	// operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [DIST_W-1:0]  dist_t;
	typedef logic [COLOR_W:0]   index_ext_t;

	// tag that travels with each palette read through the scan pipeline
	typedef struct packed {
		logic  valid;
		logic  first;
		logic  last;
		logic  live;
		addr_t index;
	} npc_tag_t;

endpackage

`default_nettype wire

### hdl/npc_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module npc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### hdl/npc_dist.sv
// manhattan distance stage between a palette entry and the query colour
// depends on npc_pkg
`default_nettype none

module npc_dist (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire npc_pkg::npc_tag_t tag_s1,
	input  wire npc_pkg::entry_t   entry,
	input  wire npc_pkg::chan_t    red,
	input  wire npc_pkg::chan_t    green,
	input  wire npc_pkg::chan_t    blue,
	output npc_pkg::npc_tag_t      tag_s2,
	output npc_pkg::dist_t         dist_s2
);

	npc_pkg::entry_t entry_m;
	npc_pkg::chan_t  er, eg, eb;
	npc_pkg::chan_t  dr, dg, db;
	npc_pkg::dist_t  dist_sum;

	// entries never written read as zero
	always_comb begin
		entry_m = tag_s1.live ? entry : '0;
		er = entry_m[3*npc_pkg::CHAN_W-1:2*npc_pkg::CHAN_W];
		eg = entry_m[2*npc_pkg::CHAN_W-1:npc_pkg::CHAN_W];
		eb = entry_m[npc_pkg::CHAN_W-1:0];
		dr = (red >= er) ? (red - er) : (er - red);
		dg = (green >= eg) ? (green - eg) : (eg - green);
		db = (blue >= eb) ? (blue - eb) : (eb - blue);
		dist_sum = npc_pkg::dist_t'(dr) + npc_pkg::dist_t'(dg) + npc_pkg::dist_t'(db);
	end

	// tag register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	// distance register
	always_ff @(posedge clk) begin
		dist_s2 <= dist_sum;
	end

endmodule

`default_nettype wire

### hdl/nearest_palette_color_core.sv
// nearest palette colour search over N = PALETTE_ENTRIES entries: busy drops with the done strobe,
// and no new lookup or write is taken until busy has dropped;
// the scan reads one palette ram word per cycle through a single read port.
// a write is taken only while idle, raises no busy and gives no result.
// reset clears the per-entry valid bits, so the palette reads all zeros with no clearing pass.
// depends on npc_pkg, npc_ram, npc_dist and nearest_palette_color_core_defines.svh
`default_nettype none
`include "nearest_palette_color_core_defines.svh"

module nearest_palette_color_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             operation,
	input  wire npc_pkg::color_t  entry_index,
	input  wire npc_pkg::chan_t   red,
	input  wire npc_pkg::chan_t   green,
	input  wire npc_pkg::chan_t   blue,
	output logic                  done,
	output npc_pkg::color_t       color_index
);

	logic                       accept;
	logic                       wr_en;
	logic                       lookup;
	npc_pkg::addr_t             wr_addr;
	logic                       busy_q;
	logic                       issue_q;
	npc_pkg::addr_t             addr_q;
	logic [npc_pkg::PALETTE_ENTRIES-1:0] valid_q;
	npc_pkg::chan_t             red_q, green_q, blue_q;
	npc_pkg::npc_tag_t          tag_s1, tag_s2;
	npc_pkg::entry_t            rd_data;
	npc_pkg::dist_t             dist_s2;
	npc_pkg::dist_t             best_dist_q;
	npc_pkg::addr_t             best_idx_q;
	logic                       take;
	npc_pkg::addr_t             best_idx_next;
	logic                       done_q;
	npc_pkg::color_t            color_index_q;
	logic                       scan_end;

	// item decode
	always_comb begin
		accept  = start && !busy_q;
		lookup  = accept && (operation == npc_pkg::OP_LOOKUP);
		wr_en   = accept && (operation == npc_pkg::OP_WRITE)
			&& (npc_pkg::index_ext_t'(entry_index)
				< npc_pkg::index_ext_t'(npc_pkg::PALETTE_ENTRIES));
		wr_addr = entry_index[npc_pkg::ADDR_W-1:0];
		scan_end = (addr_q == npc_pkg::addr_t'(npc_pkg::PALETTE_ENTRIES - 1));
	end

	// palette storage
	npc_ram #(
		.WIDTH (npc_pkg::ENTRY_W),
		.DEPTH (npc_pkg::PALETTE_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({red, green, blue}),
		.rd_en   (issue_q),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// per-entry written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// query capture
	always_ff @(posedge clk) begin
		if (lookup) begin
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
	end

	// scan sequencer: busy for the whole lookup, issue while reads remain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= 1'b0;
			addr_q  <= '0;
		end else begin
			if (lookup) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				addr_q  <= '0;
			end else begin
				if (issue_q) begin
					if (scan_end) begin
						issue_q <= 1'b0;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				if (tag_s2.valid && tag_s2.last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// read tag, aligned with the registered ram data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= issue_q;
			tag_s1.first <= (addr_q == '0);
			tag_s1.last  <= scan_end;
			tag_s1.live  <= valid_q[addr_q];
			tag_s1.index <= addr_q;
		end
	end

	// distance stage
	npc_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s1  (tag_s1),
		.entry   (rd_data),
		.red     (red_q),
		.green   (green_q),
		.blue    (blue_q),
		.tag_s2  (tag_s2),
		.dist_s2 (dist_s2)
	);

	// running minimum, strict less-than keeps the lowest index on ties
	always_comb begin
		take          = tag_s2.valid && (tag_s2.first || (dist_s2 < best_dist_q));
		best_idx_next = take ? tag_s2.index : best_idx_q;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_dist_q <= dist_s2;
			best_idx_q  <= tag_s2.index;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tag_s2.valid && tag_s2.last;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (tag_s2.valid && tag_s2.last) begin
			color_index_q <= npc_pkg::color_t'(best_idx_next);
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign color_index = color_index_q;

	// checks
	`NPC_ASSERT_IMP(a_issue_busy, clk, arst_n, issue_q, busy_q, "read issued outside a lookup")
	`NPC_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy_q, "result shown while still busy")
	`NPC_ASSERT_NXT(a_last_done, clk, arst_n, tag_s2.valid && tag_s2.last, done_q, "final compare gave no result")
	`NPC_ASSERT_NXT(a_scan_stop, clk, arst_n, issue_q && scan_end, !issue_q, "scan ran past the last entry")
	`NPC_ASSERT_NXT(a_write_nobusy, clk, arst_n, wr_en, !busy_q && !done_q, "write started a lookup")

endmodule

`default_nettype wire
